// ===== hdl/st_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// st_pkg
// Shared types, codes and constant tables for the shape tessellator.
// ----------------------------------------------------------------------------
package st_pkg;

    localparam int MAX_SEGMENTS = 32;
    localparam int SEG_W        = 6;
    localparam int CORDIC_STEPS = 28;
    localparam int STEP_W       = 5;
    localparam int DIV_STEPS    = 32;
    localparam int DIV_CNT_W    = 5;
    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam logic signed [32:0] CORDIC_GAIN = 33'sd652032874;

    localparam logic [2:0] ACT_RECT    = 3'd0;
    localparam logic [2:0] ACT_CIRCLE  = 3'd1;
    localparam logic [2:0] ACT_ELLIPSE = 3'd2;
    localparam logic [2:0] ACT_TRI     = 3'd3;
    localparam logic [2:0] ACT_LINE    = 3'd4;
    localparam logic [2:0] ACT_FRAME   = 3'd5;

    typedef struct packed {
        logic        [2:0]  action;
        logic signed [31:0] ax;
        logic signed [31:0] ay;
        logic signed [31:0] az;
        logic signed [31:0] bx;
        logic signed [31:0] by;
        logic signed [31:0] bz;
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic signed [31:0] cz;
        logic        [31:0] shape_color;
        logic        [5:0]  segments;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic signed [31:0] vz;
        logic        [31:0] vertex_color;
        logic               has_triangle;
        logic        [31:0] tri_a;
        logic        [31:0] tri_b;
        logic        [31:0] tri_c;
        logic               last;
    } t_out_word;

    typedef enum logic [2:0] {
        K_RECT, K_CIRCLE, K_ELLIPSE, K_TRI, K_LINE, K_FRAME, K_NONE
    } t_kind;

    typedef struct packed {
        t_kind    kind;
        t_in_word word;
    } t_cmd;

    typedef struct packed {
        logic        start;
        logic [63:0] dividend;
        logic [32:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [31:0] quot;
        logic [32:0] rem;
    } t_div_rsp;

    typedef enum logic [3:0] {
        S_IDLE, S_EMIT, S_PDIV, S_CORD, S_MULC, S_MULS, S_RIM,
        S_LPREP, S_NORM, S_SQM, S_SQRT, S_LMUL, S_LDIV
    } t_bstate;

    // arctangent of 2^-k in turns, scaled by 2^32
    function automatic logic [29:0] atan_turn(input logic [STEP_W-1:0] k);
        logic [29:0] v;
        case (k)
            5'd0:  v = 30'h20000000;
            5'd1:  v = 30'h12E4051E;
            5'd2:  v = 30'h09FB385B;
            5'd3:  v = 30'h051111D4;
            5'd4:  v = 30'h028B0D43;
            5'd5:  v = 30'h0145D7E1;
            5'd6:  v = 30'h00A2F61E;
            5'd7:  v = 30'h00517C55;
            5'd8:  v = 30'h0028BE53;
            5'd9:  v = 30'h00145F2F;
            5'd10: v = 30'h000A2F98;
            5'd11: v = 30'h000517CC;
            5'd12: v = 30'h00028BE6;
            5'd13: v = 30'h000145F3;
            5'd14: v = 30'h0000A2FA;
            5'd15: v = 30'h0000517D;
            5'd16: v = 30'h000028BE;
            5'd17: v = 30'h0000145F;
            5'd18: v = 30'h00000A30;
            5'd19: v = 30'h00000518;
            5'd20: v = 30'h0000028C;
            5'd21: v = 30'h00000146;
            5'd22: v = 30'h000000A3;
            5'd23: v = 30'h00000051;
            5'd24: v = 30'h00000029;
            5'd25: v = 30'h00000014;
            5'd26: v = 30'h0000000A;
            5'd27: v = 30'h00000005;
            default: v = '0;
        endcase
        return v;
    endfunction

    // clamp a 36-bit sum to the int32 range
    function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
        logic signed [31:0] r;
        if (v[35:31] != {5{v[35]}}) begin
            r = v[35] ? {1'b1, 31'b0} : {1'b0, {31{1'b1}}};
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

// ===== hdl/shape_tessellator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shape_tessellator
// Turns shape descriptors into a stream of vertices with index triangles.
// ----------------------------------------------------------------------------
// Usage: present one shape word on i_in_word with i_in_valid; it is taken when
// o_in_ready is high. Vertices leave on o_out_word with o_out_valid/i_out_ready,
// one word per vertex, last set on the final vertex of each shape.
// A two-word queue sits between the input side and the vertex sequencer, so
// new shapes are taken while the previous one is still being expanded.
// With the sequencer idle, a taken shape word is queued, popped into the
// sequencer and then presented through the output register.
// Work per shape, done by the single sequencer after taking it:
//   rect and triangle: one emit per vertex (4 or 3).
//   circle/ellipse: a centre emit, the phase step divide, then for each of the
//   n <= 32 rim vertices 28 CORDIC steps, two multiplies on the shared multiplier, one emit.
//   line: setup, normalising (at most 30 shifts), 3 squares, 32 root steps,
//   a multiply and a 32-step divide per component, and 4 emits.
//   new-frame and unused codes: taken only, no output.
// Reset clears the queue, the output valid flag and the running base index.
// When the receiver stalls, the pending vertex holds in the output register
// and the sequencer waits; the queue keeps accepting until full.
// ----------------------------------------------------------------------------
module shape_tessellator (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  st_pkg::t_in_word  i_in_word,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output st_pkg::t_out_word o_out_word
);

    // queue between classifier and sequencer
    logic         cmd_valid;
    logic         cmd_pop;
    st_pkg::t_cmd cmd;

    st_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_pop   (cmd_pop)
    );

    // expand each shape into vertex words
    st_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

endmodule

// ===== hdl/st_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// st_front
// Accepts input words, classifies the action and queues them for the back end.
// ----------------------------------------------------------------------------
module st_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  st_pkg::t_in_word i_in_word,
    output logic             o_cmd_valid,
    output st_pkg::t_cmd     o_cmd,
    input  logic             i_cmd_pop
);

    st_pkg::t_cmd                r_q [st_pkg::QUEUE_DEPTH];
    logic [st_pkg::QPTR_W-1:0]   r_wr_ptr;
    logic [st_pkg::QPTR_W-1:0]   r_rd_ptr;
    logic [st_pkg::QCNT_W-1:0]   r_count;
    logic                        push;
    st_pkg::t_kind               kind;

    assign o_in_ready  = (r_count != st_pkg::QCNT_W'(st_pkg::QUEUE_DEPTH));
    assign push        = i_in_valid && o_in_ready;
    assign o_cmd_valid = (r_count != '0);
    assign o_cmd       = r_q[r_rd_ptr];

    always_comb begin
        case (i_in_word.action)
            st_pkg::ACT_RECT:    kind = st_pkg::K_RECT;
            st_pkg::ACT_CIRCLE:  kind = st_pkg::K_CIRCLE;
            st_pkg::ACT_ELLIPSE: kind = st_pkg::K_ELLIPSE;
            st_pkg::ACT_TRI:     kind = st_pkg::K_TRI;
            st_pkg::ACT_LINE:    kind = st_pkg::K_LINE;
            st_pkg::ACT_FRAME:   kind = st_pkg::K_FRAME;
            default:             kind = st_pkg::K_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= '{kind: kind, word: i_in_word};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_cmd_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({push, i_cmd_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd_pop |-> (r_count != '0))
        else $error("queue popped while empty");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= st_pkg::QCNT_W'(st_pkg::QUEUE_DEPTH))
        else $error("queue count beyond depth");
`endif

endmodule

// ===== hdl/st_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// st_div
// Restoring divider, one quotient bit a cycle; the quotient must fit 32 bits.
// ----------------------------------------------------------------------------
module st_div (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  st_pkg::t_div_req i_req,
    output st_pkg::t_div_rsp o_rsp
);

    logic [32:0]                  r_rem;
    logic [31:0]                  r_quo;
    logic [32:0]                  r_dvs;
    logic [st_pkg::DIV_CNT_W-1:0] r_cnt;
    logic                         r_busy;
    logic                         r_done;
    logic [33:0]                  trial;
    logic [34:0]                  diff;
    logic                         ge;

    assign trial = {r_rem, r_quo[31]};
    assign diff  = {1'b0, trial} - {2'b0, r_dvs};
    assign ge    = !diff[34];

    assign o_rsp = '{busy: r_busy, done: r_done, quot: r_quo, rem: r_rem};

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= {1'b0, i_req.dividend[63:32]};
            r_quo <= i_req.dividend[31:0];
            r_dvs <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= ge ? diff[32:0] : trial[32:0];
            r_quo <= {r_quo[30:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == st_pkg::DIV_CNT_W'(st_pkg::DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

// ===== hdl/st_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// st_back
// Sequencer that turns one queued shape into its vertices: CORDIC, square
// root, shared multiplier and divider, and the output register.
// ----------------------------------------------------------------------------
module st_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cmd_valid,
    input  st_pkg::t_cmd      i_cmd,
    output logic              o_cmd_pop,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output st_pkg::t_out_word o_out_word
);

    st_pkg::t_bstate   r_state, n_state;
    st_pkg::t_cmd      r_cmd;
    st_pkg::t_in_word  w;
    logic [31:0]       r_base;
    logic [st_pkg::SEG_W-1:0] r_n, r_vidx, r_r, r_rr;
    logic [31:0]       r_q, r_ph;
    logic signed [32:0] r_cx, r_cy, r_cz;
    logic [st_pkg::STEP_W-1:0] r_step;
    logic signed [62:0] r_pc, r_ps;
    logic [32:0]       r_m [3];
    logic [32:0]       r_mx;
    logic [63:0]       r_sum, r_sq_n, r_sq_res, r_sq_bit;
    logic signed [32:0] r_o [3];
    logic [1:0]        r_li;
    logic [31:0]       r_th;
    logic              r_ovalid;
    st_pkg::t_out_word r_oword;

    logic              out_free, is_circ, finish, emit_last, rim_last, div_start;
    st_pkg::t_div_req  div_req;
    st_pkg::t_div_rsp  div_rsp;
    logic signed [32:0] d [3];
    logic [32:0]       m [3];
    logic [32:0]       mx;
    logic signed [33:0] cos_v, sin_v, mul_a, mul_b;
    logic signed [67:0] mul_p;
    logic signed [32:0] cdx, cdy;
    logic [6:0]        rsum;
    logic              wrap;
    logic [st_pkg::SEG_W-1:0] n_rr;
    logic [31:0]       n_ph;
    logic [63:0]       sq_tb;
    logic [1:0]        vi;
    logic signed [31:0] px, py, pz;
    logic signed [33:0] ox, oy, oz, tx, ty, tz;
    st_pkg::t_out_word emit_word, rim_word;
    logic [63:0]       rc_sum, rs_sum;
    logic signed [63:0] rc_sh, rs_sh;
    logic [st_pkg::SEG_W-1:0] rim_next;
    logic [31:0]       inc;
    logic              lneg;
    logic [32:0]       lq;

    assign w           = r_cmd.word;
    assign out_free    = !r_ovalid || i_out_ready;
    assign is_circ     = (r_cmd.kind == st_pkg::K_CIRCLE) || (r_cmd.kind == st_pkg::K_ELLIPSE);
    assign o_out_valid = r_ovalid;
    assign o_out_word  = r_oword;

    st_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // line direction and magnitudes
    always_comb begin
        d[0] = {w.bx[31], w.bx} - {w.ax[31], w.ax};
        d[1] = {w.by[31], w.by} - {w.ay[31], w.ay};
        d[2] = {w.bz[31], w.bz} - {w.az[31], w.az};
        for (int k = 0; k < 3; k++) begin
            m[k] = d[k][32] ? 33'(-d[k]) : 33'(d[k]);
        end
        mx = m[0];
        if (m[1] > mx) mx = m[1];
        if (m[2] > mx) mx = m[2];
    end

    // CORDIC micro-rotation and quadrant fold
    assign cdx = r_cy >>> r_step;
    assign cdy = r_cx >>> r_step;

    always_comb begin
        case (r_ph[31:30])
            2'd0:    begin cos_v = {r_cx[32], r_cx};     sin_v = {r_cy[32], r_cy};     end
            2'd1:    begin cos_v = -{r_cy[32], r_cy};    sin_v = {r_cx[32], r_cx};     end
            2'd2:    begin cos_v = -{r_cx[32], r_cx};    sin_v = -{r_cy[32], r_cy};    end
            default: begin cos_v = {r_cy[32], r_cy};     sin_v = -{r_cx[32], r_cx};    end
        endcase
    end

    // shared multiplier
    always_comb begin
        case (r_state)
            st_pkg::S_MULC: begin mul_a = cos_v; mul_b = {{2{w.bx[31]}}, w.bx}; end
            st_pkg::S_MULS: begin
                mul_a = sin_v;
                mul_b = (r_cmd.kind == st_pkg::K_CIRCLE) ? {{2{w.bx[31]}}, w.bx}
                                                         : {{2{w.by[31]}}, w.by};
            end
            st_pkg::S_SQM:  begin mul_a = {1'b0, r_m[r_li]}; mul_b = {1'b0, r_m[r_li]}; end
            st_pkg::S_LMUL: begin mul_a = {1'b0, r_m[r_li]}; mul_b = {2'b0, r_th}; end
            default:        begin mul_a = '0; mul_b = '0; end
        endcase
    end
    assign mul_p = mul_a * mul_b;

    // phase step for the next rim vertex
    assign rsum = {1'b0, r_rr} + {1'b0, r_r};
    assign wrap = (rsum >= {1'b0, r_n});
    assign n_rr = wrap ? st_pkg::SEG_W'(rsum - {1'b0, r_n}) : rsum[st_pkg::SEG_W-1:0];
    assign n_ph = r_ph + r_q + {31'b0, wrap};

    assign sq_tb = r_sq_res + r_sq_bit;

    // divider requests: rim phase step and line offset components
    assign div_start = ((r_state == st_pkg::S_EMIT) && out_free && is_circ && (r_n != '0))
                    || (r_state == st_pkg::S_LMUL);
    always_comb begin
        div_req.start = div_start;
        if (r_state == st_pkg::S_LMUL) begin
            div_req.dividend = mul_p[63:0] + r_sq_res;
            div_req.divisor  = {r_sq_res[31:0], 1'b0};
        end else begin
            div_req.dividend = 64'h0000_0000_FFFF_FFFF;
            div_req.divisor  = {27'b0, r_n};
        end
    end

    assign lneg = d[r_li][32] ^ w.cx[31];
    assign lq   = lneg ? 33'(-{1'b0, div_rsp.quot}) : {1'b0, div_rsp.quot};

    // corner vertices: rect, triangle, line quad, circle centre
    always_comb begin
        vi = r_vidx[1:0];
        px = w.ax; py = w.ay; pz = w.az;
        ox = '0; oy = '0; oz = '0;
        tx = -{r_o[1][32], r_o[1]};
        ty = {r_o[0][32], r_o[0]};
        tz = {r_o[2][32], r_o[2]};
        case (r_cmd.kind)
            st_pkg::K_RECT: begin
                if (vi == 2'd1 || vi == 2'd2) ox = {{2{w.bx[31]}}, w.bx};
                if (vi[1]) oy = {{2{w.by[31]}}, w.by};
            end
            st_pkg::K_TRI: begin
                if (vi == 2'd1) begin
                    px = w.bx; py = w.by; pz = w.bz;
                end else if (vi == 2'd2) begin
                    px = w.cx; py = w.cy; pz = w.cz;
                end
            end
            st_pkg::K_LINE: begin
                if (vi == 2'd1 || vi == 2'd2) begin
                    px = w.bx; py = w.by; pz = w.bz;
                end
                ox = vi[1] ? -tx : tx;
                oy = vi[1] ? -ty : ty;
                oz = vi[1] ? -tz : tz;
            end
            default: ;
        endcase
        case (r_cmd.kind)
            st_pkg::K_RECT, st_pkg::K_LINE: emit_last = (vi == 2'd3);
            st_pkg::K_TRI:                  emit_last = (vi == 2'd2);
            default:                        emit_last = (r_n == '0);
        endcase
        emit_word.vx = st_pkg::sat32({{4{px[31]}}, px} + {{2{ox[33]}}, ox});
        emit_word.vy = st_pkg::sat32({{4{py[31]}}, py} + {{2{oy[33]}}, oy});
        emit_word.vz = st_pkg::sat32({{4{pz[31]}}, pz} + {{2{oz[33]}}, oz});
        emit_word.vertex_color = w.shape_color;
        emit_word.has_triangle = !is_circ && vi[1];
        emit_word.tri_a = emit_word.has_triangle ? r_base : '0;
        emit_word.tri_b = emit_word.has_triangle ? r_base + {30'b0, vi} - 32'd1 : '0;
        emit_word.tri_c = emit_word.has_triangle ? r_base + {30'b0, vi} : '0;
        emit_word.last  = emit_last;
    end

    // rim vertex from registered products, rounded half up
    always_comb begin
        rc_sum   = {r_pc[62], r_pc} + 64'd536870912;
        rs_sum   = {r_ps[62], r_ps} + 64'd536870912;
        rc_sh    = $signed(rc_sum) >>> 30;
        rs_sh    = $signed(rs_sum) >>> 30;
        rim_last = ((r_vidx + 1'b1) == r_n);
        rim_next = rim_last ? '0 : r_vidx + 1'b1;
        rim_word.vx = st_pkg::sat32({{4{w.ax[31]}}, w.ax} + rc_sh[35:0]);
        rim_word.vy = st_pkg::sat32({{4{w.ay[31]}}, w.ay} + rs_sh[35:0]);
        rim_word.vz = w.az;
        rim_word.vertex_color = w.shape_color;
        rim_word.has_triangle = 1'b1;
        rim_word.tri_a = r_base;
        rim_word.tri_b = r_base + {26'b0, r_vidx} + 32'd1;
        rim_word.tri_c = r_base + {26'b0, rim_next} + 32'd1;
        rim_word.last  = rim_last;
    end

    always_comb begin
        case (r_cmd.kind)
            st_pkg::K_TRI:                  inc = 32'd3;
            st_pkg::K_RECT, st_pkg::K_LINE: inc = 32'd4;
            default:                        inc = {26'b0, r_n} + 32'd1;
        endcase
    end

    // next state
    always_comb begin
        n_state   = r_state;
        o_cmd_pop = 1'b0;
        finish    = 1'b0;
        case (r_state)
            st_pkg::S_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    case (i_cmd.kind)
                        st_pkg::K_RECT, st_pkg::K_TRI,
                        st_pkg::K_CIRCLE, st_pkg::K_ELLIPSE: n_state = st_pkg::S_EMIT;
                        st_pkg::K_LINE:                      n_state = st_pkg::S_LPREP;
                        default:                             n_state = st_pkg::S_IDLE;
                    endcase
                end
            end
            st_pkg::S_EMIT: begin
                if (out_free) begin
                    if (emit_last) begin
                        finish  = 1'b1;
                        n_state = st_pkg::S_IDLE;
                    end else if (is_circ) begin
                        n_state = st_pkg::S_PDIV;
                    end
                end
            end
            st_pkg::S_PDIV: if (div_rsp.done) n_state = st_pkg::S_CORD;
            st_pkg::S_CORD: begin
                if (r_step == st_pkg::STEP_W'(st_pkg::CORDIC_STEPS - 1)) n_state = st_pkg::S_MULC;
            end
            st_pkg::S_MULC: n_state = st_pkg::S_MULS;
            st_pkg::S_MULS: n_state = st_pkg::S_RIM;
            st_pkg::S_RIM: begin
                if (out_free) begin
                    if (rim_last) begin
                        finish  = 1'b1;
                        n_state = st_pkg::S_IDLE;
                    end else begin
                        n_state = st_pkg::S_CORD;
                    end
                end
            end
            st_pkg::S_LPREP: n_state = (mx == '0) ? st_pkg::S_EMIT : st_pkg::S_NORM;
            st_pkg::S_NORM: begin
                if (r_mx[32:31] == 2'b00 && r_mx[30]) n_state = st_pkg::S_SQM;
            end
            st_pkg::S_SQM:  if (r_li == 2'd2) n_state = st_pkg::S_SQRT;
            st_pkg::S_SQRT: if (r_sq_bit[0]) n_state = st_pkg::S_LMUL;
            st_pkg::S_LMUL: n_state = st_pkg::S_LDIV;
            st_pkg::S_LDIV: begin
                if (div_rsp.done) n_state = (r_li == 2'd2) ? st_pkg::S_EMIT : st_pkg::S_LMUL;
            end
            default: n_state = st_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= st_pkg::S_IDLE;
            r_ovalid <= 1'b0;
            r_base   <= '0;
        end else begin
            r_state <= n_state;
            if (((r_state == st_pkg::S_EMIT) || (r_state == st_pkg::S_RIM)) && out_free) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
            if (o_cmd_pop && i_cmd.kind == st_pkg::K_FRAME) begin
                r_base <= '0;
            end else if (finish) begin
                r_base <= r_base + inc;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            st_pkg::S_IDLE: begin
                r_cmd  <= i_cmd;
                r_vidx <= '0;
                r_n    <= (i_cmd.word.segments > st_pkg::SEG_W'(st_pkg::MAX_SEGMENTS))
                        ? st_pkg::SEG_W'(st_pkg::MAX_SEGMENTS) : i_cmd.word.segments;
            end
            st_pkg::S_EMIT: begin
                if (out_free) begin
                    r_oword <= emit_word;
                    r_vidx  <= r_vidx + 1'b1;
                end
            end
            st_pkg::S_PDIV: begin
                if (div_rsp.done) begin
                    if (div_rsp.rem[5:0] + 6'd1 == r_n) begin
                        r_q <= div_rsp.quot + 32'd1;
                        r_r <= '0;
                    end else begin
                        r_q <= div_rsp.quot;
                        r_r <= div_rsp.rem[5:0] + 6'd1;
                    end
                    r_ph   <= '0;
                    r_rr   <= '0;
                    r_vidx <= '0;
                    r_cx   <= st_pkg::CORDIC_GAIN;
                    r_cy   <= '0;
                    r_cz   <= '0;
                    r_step <= '0;
                end
            end
            st_pkg::S_CORD: begin
                if (!r_cz[32]) begin
                    r_cx <= r_cx - cdx;
                    r_cy <= r_cy + cdy;
                    r_cz <= r_cz - $signed({3'b0, st_pkg::atan_turn(r_step)});
                end else begin
                    r_cx <= r_cx + cdx;
                    r_cy <= r_cy - cdy;
                    r_cz <= r_cz + $signed({3'b0, st_pkg::atan_turn(r_step)});
                end
                r_step <= r_step + 1'b1;
            end
            st_pkg::S_MULC: r_pc <= mul_p[62:0];
            st_pkg::S_MULS: r_ps <= mul_p[62:0];
            st_pkg::S_RIM: begin
                if (out_free) begin
                    r_oword <= rim_word;
                    r_vidx  <= r_vidx + 1'b1;
                    r_ph    <= n_ph;
                    r_rr    <= n_rr;
                    r_cx    <= st_pkg::CORDIC_GAIN;
                    r_cy    <= '0;
                    r_cz    <= {3'b0, n_ph[29:0]};
                    r_step  <= '0;
                end
            end
            st_pkg::S_LPREP: begin
                for (int k = 0; k < 3; k++) begin
                    r_m[k] <= m[k];
                    r_o[k] <= '0;
                end
                r_mx <= mx;
                r_th <= w.cx[31] ? 32'(-w.cx) : 32'(w.cx);
            end
            st_pkg::S_NORM: begin
                if (r_mx[32:31] != 2'b00) begin
                    for (int k = 0; k < 3; k++) r_m[k] <= r_m[k] >> 1;
                    r_mx <= r_mx >> 1;
                end else if (!r_mx[30]) begin
                    for (int k = 0; k < 3; k++) r_m[k] <= r_m[k] << 1;
                    r_mx <= r_mx << 1;
                end else begin
                    r_li  <= '0;
                    r_sum <= '0;
                end
            end
            st_pkg::S_SQM: begin
                r_sum <= r_sum + mul_p[63:0];
                r_li  <= (r_li == 2'd2) ? 2'd0 : r_li + 1'b1;
                if (r_li == 2'd2) begin
                    r_sq_n   <= r_sum + mul_p[63:0];
                    r_sq_res <= '0;
                    r_sq_bit <= 64'h4000_0000_0000_0000;
                end
            end
            st_pkg::S_SQRT: begin
                if (r_sq_n >= sq_tb) begin
                    r_sq_n   <= r_sq_n - sq_tb;
                    r_sq_res <= (r_sq_res >> 1) + r_sq_bit;
                end else begin
                    r_sq_res <= r_sq_res >> 1;
                end
                r_sq_bit <= r_sq_bit >> 2;
            end
            st_pkg::S_LDIV: begin
                if (div_rsp.done) begin
                    r_o[r_li] <= lq;
                    r_li      <= r_li + 1'b1;
                    if (r_li == 2'd2) r_vidx <= '0;
                end
            end
            default: ;
        endcase
    end

`ifndef SYNTHESIS
    a_rim_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == st_pkg::S_RIM) |-> (r_vidx < r_n))
        else $error("rim vertex beyond segment count");
    a_norm_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(r_state) == st_pkg::S_NORM && r_state == st_pkg::S_SQM)
            |-> (r_mx[32:30] == 3'b001))
        else $error("direction not normalised");
    a_idle_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == st_pkg::S_IDLE) |-> !div_rsp.busy)
        else $error("divider busy while idle");
`endif

endmodule

// ===== bench/shape_vertex_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shape_vertex_checker
// Watches both channels of the shape tessellator, predicts every vertex word
// from each accepted shape word and compares the two field by field.
// ----------------------------------------------------------------------------
module shape_vertex_checker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_ready,
    input  st_pkg::t_in_word  i_in_word,
    input  logic              i_out_valid,
    input  logic              i_out_ready,
    input  st_pkg::t_out_word i_out_word,
    output int                o_fail_count,
    output int                o_pending,
    output int                o_vertex_count,
    output int                o_shape_count
);

    localparam longint ATAN_TURN [28] = '{
        64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
        64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
        64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
        64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
        64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051, 64'h00000029,
        64'h00000014, 64'h0000000A, 64'h00000005};

    st_pkg::t_out_word vertex_q[$];
    logic [31:0]       vertex_base;

    assign o_pending = vertex_q.size();

    function automatic logic signed [31:0] clamp32(input longint v);
        if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    // floor shift for negative values too
    function automatic longint asr(input longint v, input int k);
        return v >>> k;
    endfunction

    function automatic void cordic_q30(input logic [31:0] phase,
                                       output longint c, output longint s);
        longint x, y, z, dx, dy;
        x = st_pkg::CORDIC_GAIN;
        y = 0;
        z = longint'(phase[29:0]);
        for (int k = 0; k < 28; k++) begin
            dx = asr(y, k);
            dy = asr(x, k);
            if (z >= 0) begin
                x -= dx; y += dy; z -= ATAN_TURN[k];
            end else begin
                x += dx; y -= dy; z += ATAN_TURN[k];
            end
        end
        case (phase[31:30])
            2'd0: begin c = x;  s = y;  end
            2'd1: begin c = -y; s = x;  end
            2'd2: begin c = -x; s = -y; end
            default: begin c = y; s = -x; end
        endcase
    endfunction

    function automatic longint scale30(input longint f, input longint v);
        return asr(f * v + (64'sd1 <<< 29), 30);
    endfunction

    function automatic logic [63:0] root64(input logic [63:0] n);
        logic [63:0] res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= res + b) begin
                n -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    function automatic void line_offset(input longint d[3], input longint thick,
                                        output longint o[3]);
        logic [63:0] m[3], mx, total, len2, th, q;
        mx = 0;
        for (int i = 0; i < 3; i++) begin
            m[i] = d[i] < 0 ? -d[i] : d[i];
            if (m[i] > mx) mx = m[i];
        end
        if (mx == 0) begin
            o[0] = 0; o[1] = 0; o[2] = 0;
            return;
        end
        while (mx >= (64'd1 << 31)) begin
            for (int i = 0; i < 3; i++) m[i] >>= 1;
            mx >>= 1;
        end
        while (mx < (64'd1 << 30)) begin
            for (int i = 0; i < 3; i++) m[i] <<= 1;
            mx <<= 1;
        end
        total = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
        len2 = 2 * root64(total);
        th = thick < 0 ? -thick : thick;
        for (int i = 0; i < 3; i++) begin
            q = (m[i] * th + len2 / 2) / len2;
            o[i] = ((d[i] < 0) != (thick < 0)) ? -longint'(q) : longint'(q);
        end
    endfunction

    function automatic void push_vertex(input longint x, input longint y,
                                        input longint z, input logic [31:0] col,
                                        input logic has_tri, input logic [31:0] a,
                                        input logic [31:0] b, input logic [31:0] c,
                                        input logic fin);
        st_pkg::t_out_word w;
        w.vx = clamp32(x);
        w.vy = clamp32(y);
        w.vz = clamp32(z);
        w.vertex_color = col;
        w.has_triangle = has_tri;
        w.tri_a = has_tri ? a : '0;
        w.tri_b = has_tri ? b : '0;
        w.tri_c = has_tri ? c : '0;
        w.last = fin;
        vertex_q.insert(vertex_q.size(), w);
    endfunction

    function automatic void push_quad(input longint p[4][3], input logic [31:0] col,
                                      input logic [31:0] s);
        push_vertex(p[0][0], p[0][1], p[0][2], col, 0, 0, 0, 0, 0);
        push_vertex(p[1][0], p[1][1], p[1][2], col, 0, 0, 0, 0, 0);
        push_vertex(p[2][0], p[2][1], p[2][2], col, 1, s, s + 1, s + 2, 0);
        push_vertex(p[3][0], p[3][1], p[3][2], col, 1, s, s + 2, s + 3, 1);
    endfunction

    // expand one shape word into its vertex words
    function automatic void tessellate(input st_pkg::t_in_word w);
        longint ax, ay, az, bx, by, bz, cx, cy, cz, ry, c, sn;
        longint p[4][3], d[3], o[3], t[3];
        logic [31:0] s, n, phase;
        ax = w.ax; ay = w.ay; az = w.az;
        bx = w.bx; by = w.by; bz = w.bz;
        cx = w.cx; cy = w.cy; cz = w.cz;
        s = vertex_base;
        case (w.action)
            st_pkg::ACT_RECT: begin
                p = '{'{ax, ay, az}, '{ax + bx, ay, az},
                      '{ax + bx, ay + by, az}, '{ax, ay + by, az}};
                push_quad(p, w.shape_color, s);
                vertex_base = s + 4;
            end
            st_pkg::ACT_CIRCLE, st_pkg::ACT_ELLIPSE: begin
                n = (w.segments > 6'(st_pkg::MAX_SEGMENTS))
                  ? 32'(st_pkg::MAX_SEGMENTS) : {26'b0, w.segments};
                ry = (w.action == st_pkg::ACT_CIRCLE) ? bx : by;
                push_vertex(ax, ay, az, w.shape_color, 0, 0, 0, 0, n == 0);
                for (int unsigned i = 0; i < n; i++) begin
                    phase = 32'({i, 32'd0} / {32'd0, n});
                    cordic_q30(phase, c, sn);
                    push_vertex(ax + scale30(c, bx), ay + scale30(sn, ry), az,
                                w.shape_color, 1, s, s + i + 1,
                                s + (i + 1) % n + 1, i + 1 == n);
                end
                vertex_base = s + n + 1;
            end
            st_pkg::ACT_TRI: begin
                push_vertex(ax, ay, az, w.shape_color, 0, 0, 0, 0, 0);
                push_vertex(bx, by, bz, w.shape_color, 0, 0, 0, 0, 0);
                push_vertex(cx, cy, cz, w.shape_color, 1, s, s + 1, s + 2, 1);
                vertex_base = s + 3;
            end
            st_pkg::ACT_LINE: begin
                d = '{bx - ax, by - ay, bz - az};
                line_offset(d, cx, o);
                t = '{-o[1], o[0], o[2]};
                p = '{'{ax + t[0], ay + t[1], az + t[2]},
                      '{bx + t[0], by + t[1], bz + t[2]},
                      '{bx - t[0], by - t[1], bz - t[2]},
                      '{ax - t[0], ay - t[1], az - t[2]}};
                push_quad(p, w.shape_color, s);
                vertex_base = s + 4;
            end
            st_pkg::ACT_FRAME: vertex_base = '0;
            default: ;
        endcase
    endfunction

    always @(posedge i_clk) begin
        st_pkg::t_out_word want;
        if (!i_rst_n) begin
            vertex_q.delete();
            vertex_base = '0;
            o_fail_count <= 0;
            o_vertex_count <= 0;
            o_shape_count <= 0;
        end else begin
            // compare before predicting; a new shape never yields a word this edge
            if (i_out_valid && i_out_ready) begin
                o_vertex_count <= o_vertex_count + 1;
                if (vertex_q.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("%0t: unexpected vertex word %h", $realtime,
                                 i_out_word);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = vertex_q.pop_front();
                    if (want !== i_out_word) begin
                        if (o_fail_count < 10) begin
                            $display("%0t: vertex mismatch x %h/%h y %h/%h z %h/%h col %h/%h",
                                $realtime, want.vx, i_out_word.vx, want.vy,
                                i_out_word.vy, want.vz, i_out_word.vz,
                                want.vertex_color, i_out_word.vertex_color);
                            $display("    tri %b/%b %h %h %h / %h %h %h last %b/%b",
                                want.has_triangle, i_out_word.has_triangle,
                                want.tri_a, want.tri_b, want.tri_c,
                                i_out_word.tri_a, i_out_word.tri_b,
                                i_out_word.tri_c, want.last, i_out_word.last);
                        end
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                o_shape_count <= o_shape_count + 1;
                tessellate(i_in_word);
            end
        end
    end

endmodule

// ===== bench/tb_shape_tessellator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_shape_tessellator
// Drives shape words into the tessellator under several idling patterns and
// lets the vertex checker judge every vertex word that comes out.
// ----------------------------------------------------------------------------
module tb_shape_tessellator;

    logic              i_clk;
    logic              i_rst_n;
    logic              in_valid;
    logic              in_ready;
    st_pkg::t_in_word  in_word;
    logic              out_valid;
    logic              out_ready;
    st_pkg::t_out_word out_word;
    int                fail_count;
    int                pending;
    int                vertex_count;
    int                shape_count;

    // idle and stall percentages of the current phase
    int        send_idle_pct;
    int        recv_stall_pct;

    shape_tessellator i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_word  (out_word)
    );

    shape_vertex_checker i_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (in_valid),
        .i_in_ready     (in_ready),
        .i_in_word      (in_word),
        .i_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .i_out_word     (out_word),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_vertex_count (vertex_count),
        .o_shape_count  (shape_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Worst case: ~100 words, each a 33-vertex circle, plus
    // stalls on every vertex; 10 ms covers that several times over.
    initial begin
        #10_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // Receiver: re-decide ready on every falling edge.
    always @(negedge i_clk) begin
        if (!i_rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(5))
            0: return 32'h7FFFFFFF;
            1: return 32'h80000000;
            2: return $urandom;
            default: return {10'b0, 22'($urandom_range(22'h3FFFFF))} - 32'h00200000;
        endcase
    endfunction

    // Send one word: hold valid and payload until the handshake, idle after.
    // Without idling, valid stays high for the next word.
    task automatic send_shape(input st_pkg::t_in_word w);
        logic [351:0] junk;
        in_word  <= w;
        in_valid <= 1'b1;
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
        @(negedge i_clk);
        if ($urandom_range(99) < send_idle_pct) begin
            junk = {$urandom, $urandom, $urandom, $urandom, $urandom,
                    $urandom, $urandom, $urandom, $urandom, $urandom,
                    $urandom};
            in_valid <= 1'b0;
            in_word  <= junk[$bits(st_pkg::t_in_word)-1:0];
            do @(negedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
    endtask

    task automatic make_shape(input logic [2:0] act, input logic [5:0] segs,
                              output st_pkg::t_in_word w);
        w.action      = act;
        w.ax          = rand_coord();
        w.ay          = rand_coord();
        w.az          = rand_coord();
        w.bx          = rand_coord();
        w.by          = rand_coord();
        w.bz          = rand_coord();
        w.cx          = rand_coord();
        w.cy          = rand_coord();
        w.cz          = rand_coord();
        w.shape_color = $urandom;
        w.segments    = segs;
    endtask

    task automatic run_random(input int count);
        st_pkg::t_in_word w;
        logic [2:0] act;
        logic [5:0] segs;
        for (int k = 0; k < count; k++) begin
            act  = 3'($urandom_range(7));
            // mostly small rims, now and then the largest or above it
            segs = ($urandom_range(9) == 0) ? 6'($urandom_range(63))
                                            : 6'($urandom_range(6));
            make_shape(act, segs, w);
            send_shape(w);
        end
    endtask

    initial begin
        st_pkg::t_in_word w;
        in_valid       = 1'b0;
        in_word        = '0;
        out_ready      = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        i_rst_n        = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: every action with random content
        for (int a = 0; a < 8; a++) begin
            make_shape(a[2:0], 6'd5, w);
            send_shape(w);
        end
        // rim sizes: none, one, two, the maximum and two above it
        make_shape(st_pkg::ACT_CIRCLE, 6'd0, w);   send_shape(w);
        make_shape(st_pkg::ACT_ELLIPSE, 6'd1, w);  send_shape(w);
        make_shape(st_pkg::ACT_CIRCLE, 6'd2, w);   send_shape(w);
        make_shape(st_pkg::ACT_CIRCLE, 6'd32, w);  send_shape(w);
        make_shape(st_pkg::ACT_ELLIPSE, 6'd33, w); send_shape(w);
        make_shape(st_pkg::ACT_CIRCLE, 6'd63, w);  send_shape(w);
        // zero-length line collapses onto its points
        make_shape(st_pkg::ACT_LINE, 6'd0, w);
        w.bx = w.ax; w.by = w.ay; w.bz = w.az;
        send_shape(w);
        // negative thickness and a one-axis line
        make_shape(st_pkg::ACT_LINE, 6'd0, w);
        w.by = w.ay; w.bz = w.az; w.cx = 32'shFFFE0000;
        send_shape(w);
        // saturation in both directions
        w = '{st_pkg::ACT_RECT, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
              32'h7FFFFFFF, 32'h80000000, 32'h0, 32'h0, 32'h0, 32'h0,
              32'hFFFFFFFF, 6'h3F};
        send_shape(w);
        w = '{st_pkg::ACT_ELLIPSE, 32'h80000000, 32'h7FFFFFFF, 32'h0,
              32'h7FFFFFFF, 32'h80000000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
              6'd4};
        send_shape(w);
        w = '{st_pkg::ACT_LINE, 32'h80000000, 32'h80000000, 32'h80000000,
              32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h0,
              32'h0, 32'h0, 6'd0};
        send_shape(w);

        // Random phases: none, sender idle, receiver stall, both
        send_idle_pct = 0;  recv_stall_pct = 0;  run_random(20);
        send_idle_pct = 54; recv_stall_pct = 0;  run_random(20);
        send_idle_pct = 0;  recv_stall_pct = 54; run_random(20);
        send_idle_pct = 19; recv_stall_pct = 19; run_random(20);
        in_valid <= 1'b0;

        while (pending != 0) @(negedge i_clk);
        repeat (1200) @(negedge i_clk);

        $display("Run covered %0d shape words and %0d vertex words", shape_count,
                 vertex_count);
        $display("over all actions, rim sizes 0..63, and four idling patterns");
        if (fail_count == 0 && pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
